// ===== hw/rtl/mfbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfbp_pkg
// shared types and constants for the msb-first bit packer
// ----------------------------------------------------------------------------
package mfbp_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int STORE_BITS   = BUFFER_BYTES * 8;
    localparam int MAX_PUSH     = 8;
    localparam int MAX_PULL     = 16;

    localparam logic [7:0] C_CLR_MASK = 8'hfe;
    localparam logic [7:0] C_BIT_MASK = 8'h01;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_LOAD  = 2'd1,
        OP_PUSH  = 2'd2,
        OP_PULL  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ERR_OK           = 3'd0,
        ERR_CAPACITY     = 3'd1,
        ERR_LENGTH       = 3'd2,
        ERR_LEN_OVER_CAP = 3'd3,
        ERR_COUNT        = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PULL,
        S_PUSH_RD,
        S_PUSH_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic [7:0] push_value;
        logic       pull_en;
        logic [2:0] pull_sel;
        logic [2:0] push_idx;
        logic [2:0] push_sh;
    } t_shift_ctl;

endpackage

// ===== hw/rtl/mfbp_store.sv =====
// ----------------------------------------------------------------------------
// mfbp_store
// byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
module mfbp_store
    import mfbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [BUFFER_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mfbp_shifter.sv =====
// ----------------------------------------------------------------------------
// mfbp_shifter
// bit-serial datapath: pull shift register and push bit merge into a byte
// ----------------------------------------------------------------------------
module mfbp_shifter
    import mfbp_pkg::*;
(
    input  logic        i_clk,
    input  t_shift_ctl  i_ctl,
    input  logic [7:0]  i_rd_data,
    output logic [7:0]  o_wr_byte,
    output logic [15:0] o_pulled_value
);

    logic [7:0]  r_pval;
    logic [15:0] r_pull;
    logic        push_bit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pval <= i_ctl.push_value;
            r_pull <= '0;
        end else if (i_ctl.pull_en) begin
            r_pull <= {r_pull[14:0], i_rd_data[i_ctl.pull_sel]};
        end
    end

    always_comb begin
        push_bit  = r_pval[i_ctl.push_idx];
        // keep earlier bits, place the new bit, clear later bits
        o_wr_byte = (i_rd_data & (C_CLR_MASK << i_ctl.push_sh))
                  | ((C_BIT_MASK & {7'b0, push_bit}) << i_ctl.push_sh);
    end

    assign o_pulled_value = r_pull;

endmodule

// ===== hw/rtl/msb_first_bit_packer.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// bit-stream buffer over a byte store, msb first within each byte
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the cycle of o_done, which carries the result for exactly one cycle
// and cannot be held off. Start, load and every rejected item go from
// acceptance straight to the done state. A pull of n bits moves one bit
// per cycle through the registered read port of the byte store. A push of
// n bits does a read-modify-write of the store for every bit, a read state
// and then a write state per bit. The next item can be taken in the cycle
// after o_done.
// ----------------------------------------------------------------------------
module msb_first_bit_packer
    import mfbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [8:0]  i_capacity_bits,
    input  logic [8:0]  i_length_bits,
    input  logic [4:0]  i_byte_index,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_push_value,
    input  logic [4:0]  i_bit_count,
    output logic        o_done,
    output logic [15:0] o_pulled_value,
    output logic [2:0]  o_error_code,
    output logic [8:0]  o_bit_position,
    output logic [8:0]  o_valid_length
);

    t_state     r_state, n_state;
    logic [8:0] r_pos, n_pos;
    logic [8:0] r_len, n_len;
    logic [8:0] r_cap, n_cap;
    logic [4:0] r_cnt, n_cnt;
    t_err       r_err, n_err;
    logic       r_pull_vld, n_pull_vld;
    logic [2:0] r_pull_sh, n_pull_sh;

    logic              accept;
    t_err              acc_err;
    logic [9:0]        pos_sum;
    logic [9:0]        pos_inc;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;
    logic [7:0]        wr_byte;
    t_shift_ctl        shift_ctl;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        pos_sum = 10'(r_pos) + 10'(i_bit_count);
        acc_err = ERR_OK;
        case (t_op'(i_opcode))
            OP_START: begin
                if (i_length_bits > i_capacity_bits) begin
                    acc_err = ERR_LEN_OVER_CAP;
                end else if (int'(i_capacity_bits) > STORE_BITS) begin
                    acc_err = ERR_CAPACITY;
                end
            end
            OP_LOAD: begin
                if (int'(i_byte_index) >= BUFFER_BYTES) begin
                    acc_err = ERR_CAPACITY;
                end
            end
            OP_PUSH: begin
                if (int'(i_bit_count) > MAX_PUSH) begin
                    acc_err = ERR_COUNT;
                end else if (pos_sum > 10'(r_cap)) begin
                    acc_err = ERR_CAPACITY;
                end
            end
            OP_PULL: begin
                if (int'(i_bit_count) > MAX_PULL) begin
                    acc_err = ERR_COUNT;
                end else if (pos_sum > 10'(r_len)) begin
                    acc_err = ERR_LENGTH;
                end
            end
            default: acc_err = ERR_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_len      <= '0;
            r_cap      <= '0;
            r_cnt      <= '0;
            r_err      <= ERR_OK;
            r_pull_vld <= 1'b0;
            r_pull_sh  <= '0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_cap      <= n_cap;
            r_cnt      <= n_cnt;
            r_err      <= n_err;
            r_pull_vld <= n_pull_vld;
            r_pull_sh  <= n_pull_sh;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_len      = r_len;
        n_cap      = r_cap;
        n_cnt      = r_cnt;
        n_err      = r_err;
        n_pull_vld = 1'b0;
        n_pull_sh  = r_pull_sh;
        pos_inc    = 10'(r_pos) + 10'd1;

        mem_we    = 1'b0;
        mem_waddr = r_pos[ADDR_W+2:3];
        mem_wdata = wr_byte;

        shift_ctl.load       = 1'b0;
        shift_ctl.push_value = i_push_value;
        shift_ctl.pull_en    = r_pull_vld;
        shift_ctl.pull_sel   = r_pull_sh;
        shift_ctl.push_idx   = 3'(r_cnt - 5'd1);
        shift_ctl.push_sh    = ~r_pos[2:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    shift_ctl.load = 1'b1;
                    n_err          = acc_err;
                    n_cnt          = i_bit_count;
                    n_state        = S_DONE;
                    if (acc_err == ERR_OK) begin
                        case (t_op'(i_opcode))
                            OP_START: begin
                                n_cap = i_capacity_bits;
                                n_len = i_length_bits;
                                n_pos = '0;
                            end
                            OP_LOAD: begin
                                mem_we    = 1'b1;
                                mem_waddr = i_byte_index[ADDR_W-1:0];
                                mem_wdata = i_byte_value;
                            end
                            OP_PUSH: begin
                                if (i_bit_count != 5'd0) begin
                                    n_state = S_PUSH_RD;
                                end
                            end
                            OP_PULL: begin
                                n_state = S_PULL;
                            end
                            default: n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_PULL: begin
                // issue one byte read per bit, shift the bit in once the registered read returns
                if (r_cnt != 5'd0) begin
                    n_pull_vld = 1'b1;
                    n_pull_sh  = ~r_pos[2:0];
                    n_pos      = pos_inc[8:0];
                    n_cnt      = r_cnt - 5'd1;
                end else if (!r_pull_vld) begin
                    n_state = S_DONE;
                end
            end
            S_PUSH_RD: begin
                n_state = S_PUSH_WR;
            end
            S_PUSH_WR: begin
                mem_we = 1'b1;
                n_pos  = pos_inc[8:0];
                if (pos_inc > 10'(r_len)) begin
                    n_len = pos_inc[8:0];
                end
                n_cnt   = r_cnt - 5'd1;
                n_state = (r_cnt == 5'd1) ? S_DONE : S_PUSH_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    mfbp_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_pos[ADDR_W+2:3]),
        .o_rdata (mem_rdata)
    );

    mfbp_shifter u_shifter (
        .i_clk          (i_clk),
        .i_ctl          (shift_ctl),
        .i_rd_data      (mem_rdata),
        .o_wr_byte      (wr_byte),
        .o_pulled_value (o_pulled_value)
    );

    assign o_done         = (r_state == S_DONE);
    assign o_error_code   = r_err;
    assign o_bit_position = r_pos;
    assign o_valid_length = r_len;

`ifndef SYNTHESIS
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= r_len) && (r_len <= r_cap))
        else $error("position, length and capacity out of order");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result strobe longer than one cycle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_err != ERR_OK)) |-> (o_pulled_value == 16'd0))
        else $error("pulled value not zero on a rejected item");
`endif

endmodule

// ===== sim/mfbp_stream_checker.sv =====
// ----------------------------------------------------------------------------
// mfbp_stream_checker
// Watches the item and result channels of the msb-first bit packer. It keeps
// its own copy of the byte store, the position, the length and the capacity,
// works out the result of every accepted item, and compares each strobed
// result field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module mfbp_stream_checker
    import mfbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_opcode,
    input  logic [8:0]  i_capacity_bits,
    input  logic [8:0]  i_length_bits,
    input  logic [4:0]  i_byte_index,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_push_value,
    input  logic [4:0]  i_bit_count,
    input  logic        i_done,
    input  logic [15:0] i_pulled_value,
    input  logic [2:0]  i_error_code,
    input  logic [8:0]  i_bit_position,
    input  logic [8:0]  i_valid_length,
    output int          o_fail_count,
    output int          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] pulled;
        t_err        err;
        logic [8:0]  position;
        logic [8:0]  length;
    } t_stream_result;

    logic [7:0]     stream_bytes [BUFFER_BYTES];
    logic [8:0]     pos_q;
    logic [8:0]     len_q;
    logic [8:0]     cap_q;
    t_stream_result pending_results [$];
    int             fail_total;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_total++;
    endtask

    task automatic apply_stream_op(
        input  t_op            op,
        input  logic [8:0]     cap_in,
        input  logic [8:0]     len_in,
        input  logic [4:0]     idx,
        input  logic [7:0]     bval,
        input  logic [7:0]     pval,
        input  logic [4:0]     cnt,
        output t_stream_result res
    );
        int          n;
        int          byte_at;
        int          off;
        logic [7:0]  b;
        logic [7:0]  keep_mask;
        logic [15:0] pulled;
        t_err        err;
        pulled = '0;
        err    = ERR_OK;
        case (op)
            OP_START: begin
                if (len_in > cap_in) begin
                    err = ERR_LEN_OVER_CAP;
                end else if (int'(cap_in) > STORE_BITS) begin
                    err = ERR_CAPACITY;
                end else begin
                    cap_q = cap_in;
                    len_q = len_in;
                    pos_q = '0;
                end
            end
            OP_LOAD: begin
                if (int'(idx) >= BUFFER_BYTES) begin
                    err = ERR_CAPACITY;
                end else begin
                    stream_bytes[idx] = bval;
                end
            end
            OP_PUSH: begin
                if (int'(cnt) > MAX_PUSH) begin
                    err = ERR_COUNT;
                end else if (int'(pos_q) + int'(cnt) > int'(cap_q)) begin
                    err = ERR_CAPACITY;
                end else begin
                    for (n = int'(cnt) - 1; n >= 0; n--) begin
                        byte_at = int'(pos_q) >> 3;
                        off     = int'(pos_q[2:0]);
                        if (byte_at < BUFFER_BYTES) begin
                            // keep earlier bits of the byte, clear the later ones
                            keep_mask = ~(8'hff >> off);
                            b = stream_bytes[byte_at] & keep_mask;
                            b[7 - off] = pval[n];
                            stream_bytes[byte_at] = b;
                        end
                        pos_q = pos_q + 9'd1;
                        if (pos_q > len_q) begin
                            len_q = pos_q;
                        end
                    end
                end
            end
            OP_PULL: begin
                if (int'(cnt) > MAX_PULL) begin
                    err = ERR_COUNT;
                end else if (int'(pos_q) + int'(cnt) > int'(len_q)) begin
                    err = ERR_LENGTH;
                end else begin
                    for (n = 0; n < int'(cnt); n++) begin
                        b      = stream_bytes[int'(pos_q) >> 3];
                        pulled = {pulled[14:0], b[7 - int'(pos_q[2:0])]};
                        pos_q  = pos_q + 9'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        res = '{pulled, err, pos_q, len_q};
    endtask

    always @(posedge i_clk) begin
        t_stream_result want;
        t_stream_result got_next;
        if (!i_rst_n) begin
            pos_q = '0;
            len_q = '0;
            cap_q = '0;
            pending_results.delete();
        end else begin
            if (i_done) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with no item outstanding, error %0d",
                                              i_error_code));
                end else begin
                    want = pending_results.pop_front();
                    if (i_pulled_value !== want.pulled)
                        report_mismatch($sformatf("pulled_value got %h want %h",
                                                  i_pulled_value, want.pulled));
                    if (i_error_code !== want.err)
                        report_mismatch($sformatf("error_code got %0d want %0d",
                                                  i_error_code, want.err));
                    if (i_bit_position !== want.position)
                        report_mismatch($sformatf("bit_position got %0d want %0d",
                                                  i_bit_position, want.position));
                    if (i_valid_length !== want.length)
                        report_mismatch($sformatf("valid_length got %0d want %0d",
                                                  i_valid_length, want.length));
                end
            end
            if (i_start && !i_busy) begin
                apply_stream_op(t_op'(i_opcode), i_capacity_bits, i_length_bits,
                                i_byte_index, i_byte_value, i_push_value, i_bit_count,
                                got_next);
                pending_results.push_back(got_next);
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== sim/tb_msb_first_bit_packer.sv =====
// ----------------------------------------------------------------------------
// tb_msb_first_bit_packer
// Drives start, load, push and pull items into the msb-first bit packer:
// the byte store is filled first, then a directed run over the error cases
// and field extremes, then random streams with varying sender gaps. The
// checker beside the block does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_packer;

    timeunit 1ns;
    timeprecision 1ps;

    import mfbp_pkg::*;

    localparam int RANDOM_ITEMS   = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;

    typedef struct {
        t_op        op;
        logic [8:0] cap;
        logic [8:0] len;
        logic [4:0] index;
        logic [7:0] value;
        logic [7:0] pval;
        logic [4:0] count;
    } t_stream_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [8:0]  i_capacity_bits;
    logic [8:0]  i_length_bits;
    logic [4:0]  i_byte_index;
    logic [7:0]  i_byte_value;
    logic [7:0]  i_push_value;
    logic [4:0]  i_bit_count;
    logic        o_done;
    logic [15:0] o_pulled_value;
    logic [2:0]  o_error_code;
    logic [8:0]  o_bit_position;
    logic [8:0]  o_valid_length;
    int          fail_count;
    int          pending;
    int          stall_cycles = 0;
    int          idle_by_phase [4] = '{0, 60, 0, 10};

    always #5 i_clk = ~i_clk;

    msb_first_bit_packer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_capacity_bits (i_capacity_bits),
        .i_length_bits   (i_length_bits),
        .i_byte_index    (i_byte_index),
        .i_byte_value    (i_byte_value),
        .i_push_value    (i_push_value),
        .i_bit_count     (i_bit_count),
        .o_done          (o_done),
        .o_pulled_value  (o_pulled_value),
        .o_error_code    (o_error_code),
        .o_bit_position  (o_bit_position),
        .o_valid_length  (o_valid_length)
    );

    mfbp_stream_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_opcode        (i_opcode),
        .i_capacity_bits (i_capacity_bits),
        .i_length_bits   (i_length_bits),
        .i_byte_index    (i_byte_index),
        .i_byte_value    (i_byte_value),
        .i_push_value    (i_push_value),
        .i_bit_count     (i_bit_count),
        .i_done          (o_done),
        .i_pulled_value  (o_pulled_value),
        .i_error_code    (o_error_code),
        .i_bit_position  (o_bit_position),
        .i_valid_length  (o_valid_length),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    function automatic t_stream_cmd random_fields();
        t_stream_cmd c;
        c.op    = t_op'($urandom_range(3));
        c.cap   = 9'($urandom_range(511));
        c.len   = 9'($urandom_range(511));
        c.index = 5'($urandom_range(31));
        c.value = 8'($urandom_range(255));
        c.pval  = 8'($urandom_range(255));
        c.count = 5'($urandom_range(31));
        return c;
    endfunction

    // start: a = capacity, b = length; load: a = index, b = value;
    // push: a = count, b = value; pull: a = count
    function automatic t_stream_cmd make_cmd(input t_op op, input int a, input int b);
        t_stream_cmd c;
        c    = random_fields();
        c.op = op;
        case (op)
            OP_START: begin
                c.cap = 9'(a);
                c.len = 9'(b);
            end
            OP_LOAD: begin
                c.index = 5'(a);
                c.value = 8'(b);
            end
            OP_PUSH: begin
                c.count = 5'(a);
                c.pval  = 8'(b);
            end
            default: begin
                c.count = 5'(a);
            end
        endcase
        return c;
    endfunction

    function automatic t_stream_cmd random_cmd();
        t_stream_cmd c;
        int          pick;
        int          sel;
        c    = random_fields();
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        if (pick < 4) begin
            c.op = OP_START;
            if (sel < 70) begin
                c.cap = (sel < 35) ? 9'd256 : 9'($urandom_range(256));
                c.len = ($urandom_range(3) == 0) ? c.cap : 9'($urandom_range(c.cap));
            end else if (sel < 85) begin
                c.cap = 9'($urandom_range(255));
                c.len = 9'($urandom_range(511, int'(c.cap) + 1));
            end else begin
                c.cap = 9'($urandom_range(511, 257));
            end
        end else if (pick < 16) begin
            c.op = OP_LOAD;
        end else if (pick < 58) begin
            c.op    = OP_PUSH;
            c.count = (sel < 5) ? 5'($urandom_range(31, 9)) :
                      (sel < 50) ? 5'd8 : 5'($urandom_range(8));
        end else begin
            c.op    = OP_PULL;
            c.count = (sel < 5) ? 5'($urandom_range(31, 17)) :
                      (sel < 45) ? 5'd16 : 5'($urandom_range(16));
        end
        return c;
    endfunction

    task automatic issue_cmd(input t_stream_cmd c, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_opcode        <= c.op;
        i_capacity_bits <= c.cap;
        i_length_bits   <= c.len;
        i_byte_index    <= c.index;
        i_byte_value    <= c.value;
        i_push_value    <= c.pval;
        i_bit_count     <= c.count;
        do @(posedge i_clk); while (!(start && !busy));
    endtask

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_opcode        = OP_START;
        i_capacity_bits = '0;
        i_length_bits   = '0;
        i_byte_index    = '0;
        i_byte_value    = '0;
        i_push_value    = '0;
        i_bit_count     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every store byte gets written so no read ever sees an unwritten one
        for (int k = 0; k < BUFFER_BYTES; k++) begin
            issue_cmd(make_cmd(OP_LOAD, k, int'($urandom_range(255))), 0);
        end

        issue_cmd(make_cmd(OP_START, 256, 0), 0);
        issue_cmd(make_cmd(OP_PUSH, 0, 8'hff), 0);
        issue_cmd(make_cmd(OP_PULL, 0, 0), 0);
        issue_cmd(make_cmd(OP_PUSH, 8, 8'ha5), 0);
        issue_cmd(make_cmd(OP_PUSH, 9, 8'hff), 0);
        issue_cmd(make_cmd(OP_PULL, 1, 0), 0);
        issue_cmd(make_cmd(OP_PUSH, 5, 8'h3d), 0);
        issue_cmd(make_cmd(OP_START, 13, 13), 0);
        issue_cmd(make_cmd(OP_PULL, 16, 0), 0);
        issue_cmd(make_cmd(OP_PULL, 17, 0), 0);
        issue_cmd(make_cmd(OP_PULL, 13, 0), 0);
        issue_cmd(make_cmd(OP_PUSH, 1, 8'h01), 0);
        issue_cmd(make_cmd(OP_START, 20, 21), 0);
        issue_cmd(make_cmd(OP_START, 257, 0), 0);
        issue_cmd(make_cmd(OP_START, 511, 511), 0);
        issue_cmd(make_cmd(OP_LOAD, 31, 8'hff), 0);
        issue_cmd(make_cmd(OP_LOAD, 0, 8'h00), 0);
        issue_cmd(make_cmd(OP_START, 256, 256), 0);
        issue_cmd(make_cmd(OP_PULL, 16, 0), 0);
        issue_cmd(make_cmd(OP_PUSH, 31, 8'hff), 0);
        issue_cmd(make_cmd(OP_PULL, 31, 0), 0);
        issue_cmd(make_cmd(OP_PUSH, 3, 8'h02), 0);
        issue_cmd(make_cmd(OP_PULL, 0, 0), 0);
        issue_cmd(make_cmd(OP_START, 0, 0), 0);
        issue_cmd(make_cmd(OP_PUSH, 1, 8'h01), 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            issue_cmd(random_cmd(), idle_by_phase[n * 4 / RANDOM_ITEMS]);
        end
        start <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
